FILE: sv/spq_pkg.sv
// Shared types and codes of the sorted priority queue.
// No dependencies; compile first.
`timescale 1ns / 1ps

package spq_pkg;

   // Operation code carried by a request.
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

endpackage

FILE: sv/spq_if.sv
// Valid/ready channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the operation code type.
`timescale 1ns / 1ps

interface spq_req_if #(
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 16
);
   import spq_pkg::*;

   logic                             valid;
   logic                             ready;
   op_type                           op;
   logic signed [DATA_WIDTH-1:0]     item_data;
   logic signed [PRIORITY_WIDTH-1:0] item_priority;

   modport source (output valid, op, item_data, item_priority, input ready);
   modport sink   (input valid, op, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if #(
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 16,
   parameter int COUNT_WIDTH    = 5
);
   logic                             valid;
   logic                             ready;
   logic                             accepted;
   logic signed [DATA_WIDTH-1:0]     head_data;
   logic signed [PRIORITY_WIDTH-1:0] head_priority;
   logic [COUNT_WIDTH-1:0]           entry_count;
   logic                             is_empty;

   modport source (output valid, accepted, head_data, head_priority, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, accepted, head_data, head_priority, entry_count, is_empty,
                   output ready);
endinterface

FILE: sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue top level: sequencer, circular slot store, response register.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_ram.
//
//   channel | direction | payload                                              | handshake
//   req     | in        | op, item_data, item_priority                         | valid/ready
//   rsp     | out       | accepted, head_data, head_priority, entry_count,     | valid/ready
//           |           | is_empty                                             |
//
// Each request passes from idle through a head fetch to the response register; a push
// that is taken first walks back from the tail: each held entry with a larger priority
// number is moved one slot back by a RAM read and then a compare and write. The response
// register loads at the edge that returns the sequencer to idle. Each step uses the single
// RAM port pair and the one priority comparator, so one request is handled at a time.
// Reset (synchronous) empties the queue at once; slot contents stay undefined.
// A new request is taken while the previous response still waits; the sequencer
// holds before loading the next response until rsp.ready frees the register.
`timescale 1ns / 1ps

module sorted_priority_queue #(
   parameter int CAPACITY       = 16,
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ENT_W = DATA_WIDTH + PRIORITY_WIDTH;
   localparam logic [IDX_W:0]   CAP_SUM = (IDX_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_FETCH,
      S_HEAD
   } state_type;

   // Map a logical position (0 = head) onto a physical slot of the ring.
   function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type                        state_ff, state_in;
   logic [IDX_W-1:0]                 head_ff, head_in;      // physical slot of the head
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 pos_ff, pos_in;        // logical insert candidate
   logic signed [DATA_WIDTH-1:0]     new_data_ff, new_data_in;
   logic signed [PRIORITY_WIDTH-1:0] new_prio_ff, new_prio_in;
   logic                             acc_ff, acc_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_acc_ff, rsp_acc_in;
   logic signed [DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic signed [PRIORITY_WIDTH-1:0] rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]                 rsp_count_ff, rsp_count_in;
   logic                             rsp_empty_ff, rsp_empty_in;

   // RAM port signals
   logic                             ram_we;
   logic [IDX_W-1:0]                 ram_waddr;
   logic [ENT_W-1:0]                 ram_wdata;
   logic [IDX_W-1:0]                 ram_raddr;
   logic [ENT_W-1:0]                 ram_rdata;
   logic signed [PRIORITY_WIDTH-1:0] rd_prio;
   logic [IDX_W-1:0]                 pos_idx;
   logic [IDX_W-1:0]                 pos_prev_idx;

   spq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Each slot word packs priority above data.
   assign rd_prio      = $signed(ram_rdata[DATA_WIDTH +: PRIORITY_WIDTH]);
   assign pos_idx      = pos_ff[IDX_W-1:0];
   assign pos_prev_idx = pos_idx - IDX_W'(1);

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.accepted      = rsp_acc_ff;
   assign rsp.head_data     = rsp_data_ff;
   assign rsp.head_priority = rsp_prio_ff;
   assign rsp.entry_count   = rsp_count_ff;
   assign rsp.is_empty      = rsp_empty_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      new_data_in  = new_data_ff;
      new_prio_in  = new_prio_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;  // drop once taken
      rsp_acc_in   = rsp_acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      ram_we       = 1'b0;
      ram_waddr    = to_phys(head_ff, pos_idx);
      ram_wdata    = {new_prio_ff, new_data_ff};
      ram_raddr    = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               new_data_in = req.item_data;
               new_prio_in = req.item_priority;
               state_in    = S_FETCH;
               acc_in      = 1'b0;
               if (req.op == OP_PUSH) begin
                  if (count_ff != CAP_CNT) begin
                     // walk back from the tail, one entry per compare
                     acc_in   = 1'b1;
                     pos_in   = count_ff;
                     state_in = S_PUSH_RD;
                  end
               end else if (count_ff != '0) begin
                  // pop: advance the head past the removed entry
                  acc_in   = 1'b1;
                  head_in  = to_phys(head_ff, IDX_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         S_PUSH_RD: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_FETCH;
            end else begin
               ram_raddr = to_phys(head_ff, pos_prev_idx);
               state_in  = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            ram_we = 1'b1;
            if (rd_prio > new_prio_ff) begin
               // held entry is served later: move it one slot back
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - CNT_W'(1);
               state_in  = S_PUSH_RD;
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            ram_raddr = head_ff;
            state_in  = S_HEAD;
         end
         S_HEAD: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_count_in = count_ff;
               rsp_empty_in = (count_ff == '0);
               rsp_data_in  = (count_ff == '0) ? '0 : $signed(ram_rdata[DATA_WIDTH-1:0]);
               rsp_prio_in  = (count_ff == '0) ? '0 : rd_prio;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      new_data_ff  <= new_data_in;
      new_prio_ff  <= new_prio_in;
      acc_ff       <= acc_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // A taken request always moves the sequencer out of the idle state in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking a request");

   // The held count never exceeds the slot store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CAP_CNT))
      else $error("entry count beyond capacity");

   // An empty queue reports zero head fields.
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_data_ff == '0 && rsp_prio_ff == '0 &&
                                          rsp_count_ff == '0))
      else $error("empty response carries head data or a count");

   // Writes to the slot store happen only while a push walks the row.
   a_write_in_push: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_PUSH_RD || state_ff == S_PUSH_CMP))
      else $error("slot store written outside a push");
endmodule

FILE: tb/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue: directed and random push/pop traffic.
// Depends on spq_pkg, spq_if and sorted_priority_queue; predicts each response in-line.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int CAPACITY       = 16;
   localparam int DATA_WIDTH     = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int COUNT_WIDTH    = 5;
   // Worst push moves every other held entry one slot back; settle well beyond such a push.
   localparam int SETTLE_CYCLES  = 60;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int MAX_PRINTED    = 40;

   // How pushed priorities are drawn in a random round.
   typedef enum int {
      PRIO_ANY,
      PRIO_TIES,
      PRIO_CORNERS
   } prio_mode_type;

   // Queue status reported by one response.
   typedef struct {
      logic                             accepted;
      logic signed [DATA_WIDTH-1:0]     head_data;
      logic signed [PRIORITY_WIDTH-1:0] head_priority;
      logic [COUNT_WIDTH-1:0]           entry_count;
      logic                             is_empty;
   } queue_status_type;

   logic clock;
   logic reset;

   spq_req_if #(.DATA_WIDTH(DATA_WIDTH), .PRIORITY_WIDTH(PRIORITY_WIDTH)) req_ch ();
   spq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .PRIORITY_WIDTH(PRIORITY_WIDTH),
                .COUNT_WIDTH(COUNT_WIDTH)) rsp_ch ();

   sorted_priority_queue #(
      .CAPACITY       (CAPACITY),
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the sorted row: slot 0 is the head.
   logic signed [DATA_WIDTH-1:0]     held_data [CAPACITY];
   logic signed [PRIORITY_WIDTH-1:0] held_prio [CAPACITY];
   int                               held_count = 0;

   // Statuses predicted at request acceptance, oldest first.
   queue_status_type pending_status [$];

   int  mismatches       = 0;
   int  requests_sent    = 0;
   int  responses_seen   = 0;
   int  full_pushes      = 0;
   int  empty_pops       = 0;
   int  cycle_count      = 0;
   int  rsp_stall_left   = 0;
   bit  steady_flow      = 1'b0;

   always #5 clock = ~clock;

   // Kill the run if traffic stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still expected",
                  cycle_count, pending_status.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Idle length for either side; zero throughout a steady-flow stretch.
   function automatic int draw_idle();
      if (steady_flow)
         return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic logic signed [PRIORITY_WIDTH-1:0] draw_priority(
         input prio_mode_type mode);
      logic [31:0] raw;
      raw = $urandom;
      case (mode)
         PRIO_TIES: begin
            return PRIORITY_WIDTH'($urandom_range(0, 3));
         end
         PRIO_CORNERS: begin
            case (raw[1:0])
               2'd0:    return {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};
               2'd1:    return {1'b0, {(PRIORITY_WIDTH-1){1'b1}}};
               2'd2:    return '1;
               default: return '0;
            endcase
         end
         default: begin
            return raw[PRIORITY_WIDTH-1:0];
         end
      endcase
   endfunction

   // Apply one request to the shadow row and queue the status it must report.
   task automatic predict_queue_op(input op_type op,
                                   input logic signed [DATA_WIDTH-1:0] data,
                                   input logic signed [PRIORITY_WIDTH-1:0] prio);
      queue_status_type status;
      int               slot;
      bit               took;
      took = 1'b0;
      if (op == OP_PUSH) begin
         if (held_count < CAPACITY) begin
            // Land behind every entry of equal or smaller priority number.
            slot = 0;
            while (slot < held_count && held_prio[slot] <= prio)
               slot++;
            for (int i = held_count; i > slot; i--) begin
               held_data[i] = held_data[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_data[slot] = data;
            held_prio[slot] = prio;
            held_count++;
            took = 1'b1;
         end else begin
            full_pushes++;
         end
      end else begin
         if (held_count > 0) begin
            for (int i = 0; i + 1 < held_count; i++) begin
               held_data[i] = held_data[i+1];
               held_prio[i] = held_prio[i+1];
            end
            held_count--;
            took = 1'b1;
         end else begin
            empty_pops++;
         end
      end
      status.accepted      = took;
      status.head_data     = (held_count > 0) ? held_data[0] : '0;
      status.head_priority = (held_count > 0) ? held_prio[0] : '0;
      status.entry_count   = COUNT_WIDTH'(held_count);
      status.is_empty      = (held_count == 0);
      pending_status.push_back(status);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("Mismatch on response %0d, %s: got %h, expected %h",
                  responses_seen, what, got, want);
   endtask

   // Compare one accepted response against the oldest prediction.
   task automatic check_status();
      queue_status_type want;
      responses_seen++;
      if (pending_status.size() == 0) begin
         report_mismatch("unexpected response", 32'd1, 32'd0);
      end else begin
         want = pending_status.pop_front();
         if (rsp_ch.accepted !== want.accepted)
            report_mismatch("accepted", rsp_ch.accepted, want.accepted);
         if (rsp_ch.head_data !== want.head_data)
            report_mismatch("head_data", rsp_ch.head_data, want.head_data);
         if (rsp_ch.head_priority !== want.head_priority)
            report_mismatch("head_priority", rsp_ch.head_priority, want.head_priority);
         if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
         if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", rsp_ch.is_empty, want.is_empty);
      end
   endtask

   // Response side: check on each handshake, then hold ready low for a drawn stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left = draw_idle();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_status();
            rsp_stall_left = draw_idle();
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Send one request: idle for a drawn gap, present it, hold until accepted.
   // Entered and left just after a rising edge, so each call sets valid once per step.
   task automatic send_request(input op_type op,
                               input logic signed [DATA_WIDTH-1:0] data,
                               input logic signed [PRIORITY_WIDTH-1:0] prio);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.item_data     <= data;
      req_ch.item_priority <= prio;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      predict_queue_op(op, data, prio);
      requests_sent++;
   endtask

   // One random round: push share and priority style fixed, content random.
   task automatic run_round(input int push_pct, input prio_mode_type mode, input int length);
      op_type op;
      for (int n = 0; n < length; n++) begin
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         send_request(op, $urandom, draw_priority(mode));
      end
   endtask

   // Pop an empty queue right after reset: must be refused and report empty.
   task automatic test_pop_empty();
      send_request(OP_POP, 32'sh1234_5678, 16'sh0042);
      send_request(OP_POP, '1, '1);
   endtask

   // Fill to capacity with extreme values, repeated priorities and head insertions.
   task automatic test_fill_to_capacity();
      logic signed [PRIORITY_WIDTH-1:0] prios [CAPACITY] = '{
         16'sd5, 16'sh7FFF, -16'sd32768, 16'sd5, 16'sd0, -16'sd1, 16'sd5, 16'sh7FFF,
         -16'sd32768, 16'sd100, -16'sd100, 16'sd0, 16'sd5, 16'sd1, -16'sd2, 16'sd7};
      logic signed [DATA_WIDTH-1:0] datas [CAPACITY] = '{
         32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
         32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh1000_0007,
         32'sh1000_0008, 32'sh1000_0009, 32'sh1000_000A, 32'sh1000_000B,
         32'sh1000_000C, 32'sh1000_000D, 32'sh1000_000E, 32'sh1000_000F};
      for (int i = 0; i < CAPACITY; i++)
         send_request(OP_PUSH, datas[i], prios[i]);
   endtask

   // Push into a full queue, once at the head priority and once at the tail.
   task automatic test_push_full();
      send_request(OP_PUSH, 32'shDEAD_BEEF, -16'sd32768);
      send_request(OP_PUSH, 32'sh0BAD_F00D, 16'sh7FFF);
   endtask

   // Pop a few heads: equal lowest priorities must leave in arrival order.
   task automatic test_pop_order();
      repeat (4) send_request(OP_POP, $urandom, PRIORITY_WIDTH'($urandom));
   endtask

   // Mixed traffic: rounds lean toward filling, draining or neither; some run flat out.
   task automatic test_random_mix(input int rounds);
      int            pcts [3] = '{25, 50, 75};
      prio_mode_type mode;
      for (int r = 0; r < rounds; r++) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 2))
            0:       mode = PRIO_ANY;
            1:       mode = PRIO_TIES;
            default: mode = PRIO_CORNERS;
         endcase
         run_round(pcts[$urandom_range(0, 2)], mode, 40);
      end
      steady_flow = 1'b0;
   endtask

   // Alternate fill and drain bursts over a few priorities to stress tie ordering.
   task automatic test_tie_bursts(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         steady_flow = (r % 5 == 4);
         run_round((r % 2 == 0) ? 85 : 15, PRIO_TIES, 40);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      // Drive the request inputs to known values before the first edge.
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_PUSH;
      req_ch.item_data     = '0;
      req_ch.item_priority = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_pop_empty();
      test_fill_to_capacity();
      test_push_full();
      test_pop_order();
      test_random_mix(30);
      test_tie_bursts(15);

      // Drop valid, wait out every outstanding response, then watch for strays.
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d pushes refused on a full queue, %0d pops on empty",
               requests_sent, full_pushes, empty_pops);
      $display("Checked %0d responses in %0d cycles, %0d mismatches",
               responses_seen, cycle_count, mismatches);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
